/* src/pnrc_pkg.sv */
`default_nettype none

package pnrc_pkg;

    // Controller phases; the numeric value is the reported state code
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SENDING   = 3'd1,
        PH_LISTENING = 3'd2,
        PH_WAITING   = 3'd3,
        PH_AWAITING  = 3'd4,
        PH_PAIRED    = 3'd5,
        PH_FAILED    = 3'd6
    } phase_t;

    // Request kind
    localparam logic FUNC_POLL  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // Transmit status
    localparam logic [1:0] TXS_PENDING  = 2'd0;
    localparam logic [1:0] TXS_COMPLETE = 2'd1;
    localparam logic [1:0] TXS_ERROR    = 2'd2;

    // Receive events
    localparam logic [2:0] RX_NONE  = 3'd0;
    localparam logic [2:0] RX_ERROR = 3'd1;
    localparam logic [2:0] RX_OFFER = 3'd2;
    localparam logic [2:0] RX_DONE  = 3'd3;

    // Offer check outcome
    localparam logic [1:0] OFFER_REFUSED  = 2'd1;
    localparam logic [1:0] OFFER_ACCEPTED = 2'd2;

    // Binding store outcome
    localparam logic [1:0] STORE_ACTIVATE_FAIL = 2'd1;
    localparam logic [1:0] STORE_OK            = 2'd2;

    // Result codes
    localparam logic [1:0] SEND_NONE    = 2'd0;
    localparam logic [1:0] SEND_REQUEST = 2'd1;
    localparam logic [1:0] SEND_CONFIRM = 2'd2;

    localparam logic [1:0] BIND_NONE    = 2'd0;
    localparam logic [1:0] BIND_ACTIVE  = 2'd1;
    localparam logic [1:0] BIND_REVOKED = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_DEADLINE   = 3'd0;
    localparam logic [2:0] CFG_TX_TIMEOUT = 3'd1;
    localparam logic [2:0] CFG_LISTEN     = 3'd2;
    localparam logic [2:0] CFG_RETRY_MAX  = 3'd3;
    localparam logic [2:0] CFG_CONF_LIMIT = 3'd4;

    // Configuration reset values
    localparam logic [31:0] DEADLINE_RST   = 32'd60000;
    localparam logic [31:0] TX_TIMEOUT_RST = 32'd1000;
    localparam logic [31:0] LISTEN_RST     = 32'd500;
    localparam logic [31:0] RETRY_MAX_RST  = 32'd2000;
    localparam logic [7:0]  CONF_LIMIT_RST = 8'd3;

    typedef struct packed {
        logic [31:0] deadline_ms;
        logic [31:0] transmit_timeout_ms;
        logic [31:0] listen_ms;
        logic [31:0] retry_max_ms;
        logic [7:0]  confirm_limit;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic        after_send;   // 1: completed send leads to awaiting done
        logic [31:0] started_time;
        logic [31:0] phase_time;
        logic [31:0] wait_length;
        logic [7:0]  confirm_count;
    } ctx_t;

    typedef struct packed {
        logic        func;
        logic [31:0] now_ms;
        logic        start_ready;
        logic        tx_start_ok;
        logic [1:0]  tx_status;
        logic [2:0]  rx_event;
        logic [1:0]  offer_check;
        logic [1:0]  store_result;
        logic        jitter_ok;
        logic [31:0] jitter_ms;
    } item_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] send_frame;
        logic [1:0] binding_action;
    } res_t;

endpackage

`default_nettype wire

/* src/pnrc_cfg.sv */
`default_nettype none

module pnrc_cfg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    output pnrc_pkg::cfg_t      cfg
);
    import pnrc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadline_ms         <= DEADLINE_RST;
            cfg_reg.transmit_timeout_ms <= TX_TIMEOUT_RST;
            cfg_reg.listen_ms           <= LISTEN_RST;
            cfg_reg.retry_max_ms        <= RETRY_MAX_RST;
            cfg_reg.confirm_limit       <= CONF_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEADLINE:   cfg_reg.deadline_ms         <= cfg_data;
                CFG_TX_TIMEOUT: cfg_reg.transmit_timeout_ms <= cfg_data;
                CFG_LISTEN:     cfg_reg.listen_ms           <= cfg_data;
                CFG_RETRY_MAX:  cfg_reg.retry_max_ms        <= cfg_data;
                CFG_CONF_LIMIT: cfg_reg.confirm_limit       <= cfg_data[7:0];
                default: ;  // unused index, dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/pnrc_fsm.sv */
`default_nettype none

module pnrc_fsm (
    input  pnrc_pkg::cfg_t  cfg,
    input  pnrc_pkg::ctx_t  cur,
    input  pnrc_pkg::item_t item,
    output pnrc_pkg::ctx_t  nxt,
    output pnrc_pkg::res_t  res
);
    import pnrc_pkg::*;

    logic [31:0] since_start;
    logic [31:0] since_phase;
    logic [31:0] limit_ms;
    logic        deadline_hit;
    logic        phase_expired;

    assign since_start  = item.now_ms - cur.started_time;
    assign since_phase  = item.now_ms - cur.phase_time;
    assign deadline_hit = (since_start >= cfg.deadline_ms);

    // one shared compare against the phase's own limit
    always_comb
    begin
        case (cur.phase)
            PH_SENDING: limit_ms = cfg.transmit_timeout_ms;
            PH_WAITING: limit_ms = cur.wait_length;
            default:    limit_ms = cfg.listen_ms;
        endcase
    end

    assign phase_expired = (since_phase >= limit_ms);

    always_comb
    begin
        nxt                = cur;
        res.send_frame     = SEND_NONE;
        res.binding_action = BIND_NONE;

        if (item.func == FUNC_START)
        begin
            if (cur.phase != PH_IDLE || !item.start_ready)
            begin
                nxt.phase = PH_FAILED;
            end
            else
            begin
                nxt.started_time = item.now_ms;
                nxt.phase_time   = item.now_ms;
                if (!item.tx_start_ok)
                begin
                    nxt.phase = PH_FAILED;
                end
                else
                begin
                    nxt.phase      = PH_SENDING;
                    nxt.after_send = 1'b0;
                    res.send_frame = SEND_REQUEST;
                end
            end
        end
        else
        begin
            unique case (cur.phase)
                PH_SENDING:
                begin
                    if (deadline_hit)
                    begin
                        nxt.phase = PH_FAILED;
                    end
                    else if (item.tx_status == TXS_ERROR ||
                             (item.tx_status == TXS_PENDING && phase_expired))
                    begin
                        nxt.phase = PH_FAILED;
                    end
                    else if (item.tx_status == TXS_COMPLETE)
                    begin
                        nxt.phase      = cur.after_send ? PH_AWAITING : PH_LISTENING;
                        nxt.phase_time = item.now_ms;
                    end
                end
                PH_WAITING:
                begin
                    if (deadline_hit)
                    begin
                        nxt.phase = PH_FAILED;
                    end
                    else if (phase_expired)
                    begin
                        nxt.phase_time = item.now_ms;
                        if (!item.tx_start_ok)
                        begin
                            nxt.phase = PH_FAILED;
                        end
                        else
                        begin
                            nxt.phase      = PH_SENDING;
                            nxt.after_send = 1'b0;
                            res.send_frame = SEND_REQUEST;
                        end
                    end
                end
                PH_LISTENING, PH_AWAITING:
                begin
                    if (deadline_hit || item.rx_event == RX_ERROR)
                    begin
                        nxt.phase = PH_FAILED;
                    end
                    else if (item.rx_event == RX_OFFER && cur.phase == PH_LISTENING)
                    begin
                        // an offer ends the step; unknown check codes keep listening
                        if (item.offer_check == OFFER_REFUSED)
                        begin
                            nxt.phase = PH_FAILED;
                        end
                        else if (item.offer_check == OFFER_ACCEPTED)
                        begin
                            nxt.confirm_count = 8'd1;
                            nxt.phase_time    = item.now_ms;
                            if (!item.tx_start_ok)
                            begin
                                nxt.phase = PH_FAILED;
                            end
                            else
                            begin
                                nxt.phase      = PH_SENDING;
                                nxt.after_send = 1'b1;
                                res.send_frame = SEND_CONFIRM;
                            end
                        end
                    end
                    else if (item.rx_event == RX_DONE && cur.phase == PH_AWAITING)
                    begin
                        if (item.store_result == STORE_OK)
                        begin
                            nxt.phase          = PH_PAIRED;
                            res.binding_action = BIND_ACTIVE;
                        end
                        else
                        begin
                            if (item.store_result == STORE_ACTIVATE_FAIL)
                                res.binding_action = BIND_REVOKED;
                            nxt.phase = PH_FAILED;
                        end
                    end
                    else if (phase_expired)
                    begin
                        if (cur.phase == PH_AWAITING)
                        begin
                            if (cur.confirm_count >= cfg.confirm_limit)
                            begin
                                nxt.phase = PH_FAILED;
                            end
                            else
                            begin
                                nxt.confirm_count = cur.confirm_count + 8'd1;
                                nxt.phase_time    = item.now_ms;
                                if (!item.tx_start_ok)
                                begin
                                    nxt.phase = PH_FAILED;
                                end
                                else
                                begin
                                    nxt.phase      = PH_SENDING;
                                    nxt.after_send = 1'b1;
                                    res.send_frame = SEND_CONFIRM;
                                end
                            end
                        end
                        else
                        begin
                            nxt.wait_length = item.jitter_ok ? item.jitter_ms
                                                             : cfg.retry_max_ms;
                            nxt.phase_time  = item.now_ms;
                            nxt.phase       = PH_WAITING;
                        end
                    end
                end
                default: ;  // idle, paired, failed: polls change nothing
            endcase
        end

        res.phase = nxt.phase;
    end

endmodule

`default_nettype wire

/* src/pairing_node_retry_controller_unit.sv */
// Pairing node retry controller: the node side of a pairing exchange as a
// seven-state machine (idle, sending, listening, waiting, awaiting done,
// paired, failed). Each input word is a start or a poll carrying the current
// wrapping millisecond time plus the pass/fail flags from the radio, the
// crypto checks, the binding store and the jitter source; each word produces
// exactly one result word with the state after the step, the frame whose
// transmit was started (if any) and the binding commit or revoke (if any).
// Throughput is one word per cycle unless out_ready back-pressure stalls it: a
// word sits in the input register while a single pass of next-state logic (two
// 32-bit wrapping subtract/compares against the deadline and the active phase
// timer) updates the context and loads the result register once that register
// frees up. Configuration is written through cfg_we / cfg_index / cfg_data and
// must only change while the block is idle.
`default_nettype none

module pairing_node_retry_controller_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    // input word
    input  wire logic        in_valid,
    output wire logic        in_ready,
    input  wire logic        func,
    input  wire logic [31:0] now_ms,
    input  wire logic        start_ready,
    input  wire logic        tx_start_ok,
    input  wire logic [1:0]  tx_status,
    input  wire logic [2:0]  rx_event,
    input  wire logic [1:0]  offer_check,
    input  wire logic [1:0]  store_result,
    input  wire logic        jitter_ok,
    input  wire logic [31:0] jitter_ms,

    // result word
    output wire logic        out_valid,
    input  wire logic        out_ready,
    output wire logic [2:0]  state_code,
    output wire logic [1:0]  send_frame,
    output wire logic [1:0]  binding_action
);
    import pnrc_pkg::*;

    cfg_t  cfg;
    item_t item_reg;
    logic  in_valid_reg;
    ctx_t  ctx_reg;
    ctx_t  ctx_next;
    res_t  res_next;
    res_t  res_reg;
    logic  out_valid_reg;
    logic  advance;

    // Result register frees up when empty or being drained this cycle
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    pnrc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pnrc_fsm u_fsm (
        .cfg  (cfg),
        .cur  (ctx_reg),
        .item (item_reg),
        .nxt  (ctx_next),
        .res  (res_next)
    );

    // Input register: payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.func         <= func;
            item_reg.now_ms       <= now_ms;
            item_reg.start_ready  <= start_ready;
            item_reg.tx_start_ok  <= tx_start_ok;
            item_reg.tx_status    <= tx_status;
            item_reg.rx_event     <= rx_event;
            item_reg.offer_check  <= offer_check;
            item_reg.store_result <= store_result;
            item_reg.jitter_ok    <= jitter_ok;
            item_reg.jitter_ms    <= jitter_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Context and result update when the staged word moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.phase         <= PH_IDLE;
            ctx_reg.after_send    <= 1'b0;
            ctx_reg.started_time  <= '0;
            ctx_reg.phase_time    <= '0;
            ctx_reg.wait_length   <= '0;
            ctx_reg.confirm_count <= '0;
            out_valid_reg         <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
                ctx_reg <= ctx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            res_reg <= res_next;
    end

    assign out_valid      = out_valid_reg;
    assign state_code     = res_reg.phase;
    assign send_frame     = res_reg.send_frame;
    assign binding_action = res_reg.binding_action;

`ifndef SYNTHESIS
    // A started transmit always leaves the controller in sending
    a_send_in_sending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_frame != SEND_NONE |-> state_code == PH_SENDING)
        else $error("transmit reported outside sending state");

    // Binding commit only on pairing success, revoke only on failure
    a_bind_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && binding_action == BIND_ACTIVE |-> state_code == PH_PAIRED)
        else $error("binding committed without pairing");

    a_bind_revoke: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && binding_action == BIND_REVOKED |-> state_code == PH_FAILED)
        else $error("binding revoked without failure");

    // The reported state matches the context the word left behind
    a_state_tracks_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg |=> state_code == ctx_reg.phase)
        else $error("reported state differs from context");
`endif

endmodule

`default_nettype wire
